// ----- rtl/oips_pkg.sv -----
`default_nettype none

package oips_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COORD_WIDTH_MAX = 32;
    localparam int ANG_WIDTH       = 18;
    localparam int CFG_IDX_WIDTH   = 2;
    localparam int CONST_WIDTH     = 26;

    // sqrt(3) and 1/sqrt(3) in Q24
    localparam logic signed [CONST_WIDTH-1:0] SQRT3_Q24     = 26'sd29058991;
    localparam logic signed [CONST_WIDTH-1:0] INV_SQRT3_Q24 = 26'sd9686330;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_COS   = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SIN   = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STYLE = 2'd2;

    localparam logic signed [ANG_WIDTH-1:0] COS_RESET = 18'sd65536;
    localparam logic signed [ANG_WIDTH-1:0] SIN_RESET = 18'sd0;

    typedef enum logic [1:0] {
        STYLE_ORTHO     = 2'd0,
        STYLE_ISO_LEFT  = 2'd1,
        STYLE_ISO_TOP   = 2'd2,
        STYLE_ISO_RIGHT = 2'd3
    } t_style;

endpackage

`default_nettype wire

// ----- rtl/ortho_isometric_point_snap.sv -----
`default_nettype none

// Snaps a cursor point onto an ortho or isometric axis through a base point, all coordinates
// signed Q16.16. Fully pipelined: one point per clock while the output is not stalled. Each
// stage has its own valid bit and moves whenever the stage after it has room, so bubbles close
// up and a stall at the output backs up stage by stage without losing or repeating a word.
// The cosine, sine and style registers are read by the stages directly; write them only while
// the pipeline is empty. The config port never pushes back.
// Coordinates wider than 32 bits are handled on their low 32 bits and sign-extended.
module ortho_isometric_point_snap #(
    parameter int COORD_WIDTH = oips_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [oips_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  wire logic [oips_pkg::ANG_WIDTH-1:0]   i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic signed [COORD_WIDTH-1:0]    i_base_x,
    input  wire logic signed [COORD_WIDTH-1:0]    i_base_y,
    input  wire logic signed [COORD_WIDTH-1:0]    i_base_z,
    input  wire logic signed [COORD_WIDTH-1:0]    i_cursor_x,
    input  wire logic signed [COORD_WIDTH-1:0]    i_cursor_y,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic signed [COORD_WIDTH-1:0]         o_snapped_x,
    output logic signed [COORD_WIDTH-1:0]         o_snapped_y,
    output logic signed [COORD_WIDTH-1:0]         o_snapped_z,
    output logic                                  o_axis_chosen,
    output logic                                  o_clipped
);

    import oips_pkg::*;

    localparam int CW  = (COORD_WIDTH > COORD_WIDTH_MAX) ? COORD_WIDTH_MAX : COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int AW  = ANG_WIDTH;
    localparam int PW  = DW + AW;
    localparam int SW  = PW + 1;
    localparam int SW1 = SW + 1;
    localparam int XW  = SW - 15;
    localparam int MW  = XW + CONST_WIDTH;
    localparam int CMW = MW + 2;
    localparam int RW  = XW + 2;
    localparam int OPW = RW + AW;
    localparam int EW1 = OPW + 2;
    localparam int OFW = EW1 - 16;
    localparam int BW  = OFW + 1;
    localparam int NS  = 11;

    // config
    logic signed [AW-1:0] r_cos;
    logic signed [AW-1:0] r_sin;
    t_style               r_style;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos   <= COS_RESET;
            r_sin   <= SIN_RESET;
            r_style <= STYLE_ORTHO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COS:   r_cos   <= i_cfg_data;
                CFG_SIN:   r_sin   <= i_cfg_data;
                CFG_STYLE: r_style <= t_style'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // flow control
    logic [NS:1] r_vld;
    logic [NS:1] n_vld;
    logic [NS:1] rdy;

    always_comb begin
        rdy[NS] = !r_vld[NS] || !i_stall;
        for (int k = NS - 1; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld = {r_vld[NS-1:1], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_stall = !rdy[1];
    assign o_valid = r_vld[NS];

    // base point delay lines
    logic signed [CW-1:0] r_bx [1:10];
    logic signed [CW-1:0] r_by [1:10];
    logic signed [CW-1:0] r_bz [1:NS];
    logic                 r_zero [2:7];
    logic                 r_ssec [4:7];
    logic signed [XW-1:0] r_x [4:7];
    logic signed [XW-1:0] r_y [4:7];
    logic                 r_sec [8:NS];

    // stage 1: offset from base
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_dx <= DW'(signed'(i_cursor_x[CW-1:0])) - DW'(signed'(i_base_x[CW-1:0]));
            r_dy <= DW'(signed'(i_cursor_y[CW-1:0])) - DW'(signed'(i_base_y[CW-1:0]));
        end
    end

    // stage 2: rotation products
    logic signed [PW-1:0] r_cdx, r_sdy, r_cdy, r_sdx;

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_cdx     <= r_dx * r_cos;
            r_sdy     <= r_dy * r_sin;
            r_cdy     <= r_dy * r_cos;
            r_sdx     <= r_dx * r_sin;
        end
    end

    // stage 3: grid frame, Q.32
    logic signed [SW-1:0] r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_cx <= SW'(r_cdx) + SW'(r_sdy);
            r_cy <= SW'(r_cdy) - SW'(r_sdx);
        end
    end

    // stage 4: round to Q16.16, ortho axis pick
    logic signed [SW1-1:0] cx_e, cy_e, cx_mag, cy_mag;

    always_comb begin
        cx_e   = SW1'(r_cx);
        cy_e   = SW1'(r_cy);
        cx_mag = cx_e[SW1-1] ? -cx_e : cx_e;
        cy_mag = cy_e[SW1-1] ? -cy_e : cy_e;
    end

    // stage 5: sqrt3 products
    logic signed [MW-1:0] r_xs, r_xi, r_ys;

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_xs <= r_x[4] * SQRT3_Q24;
            r_xi <= r_x[4] * INV_SQRT3_Q24;
            r_ys <= r_y[4] * SQRT3_Q24;
        end
    end

    // stage 6: iso candidates
    logic signed [CMW-1:0] xs_e, xi_e, ys_e, yo_e, xo_e;
    logic signed [CMW-1:0] r_a, r_b;
    logic signed [RW-1:0]  r_inv6, r_ot1, r_ot2, r_pt1, r_pt2;

    always_comb begin
        xs_e = CMW'(r_xs);
        xi_e = CMW'(r_xi);
        ys_e = CMW'(r_ys);
        yo_e = CMW'(r_y[5]) <<< 24;
        xo_e = CMW'(r_x[5]) <<< 24;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_a    <= xs_e - yo_e;
            r_b    <= xs_e + yo_e;
            r_inv6 <= RW'((xi_e + (CMW'(1) <<< 23)) >>> 24);
            r_ot1  <= RW'((xo_e - ys_e + (CMW'(1) <<< 24)) >>> 25);
            r_ot2  <= RW'((xo_e + ys_e + (CMW'(1) <<< 24)) >>> 25);
            r_pt1  <= RW'((yo_e - xi_e + (CMW'(1) <<< 24)) >>> 25);
            r_pt2  <= RW'((yo_e + xi_e + (CMW'(1) <<< 24)) >>> 25);
        end
    end

    // stage 7: magnitudes, along-axis sums
    logic signed [CMW-1:0] y2_e;
    logic signed [CMW-1:0] r_ma, r_mb, r_my;
    logic signed [RW-1:0]  r_inv7, r_pl, r_pr, r_ot1_7, r_ot2_7, r_pt1_7, r_pt2_7;

    assign y2_e = CMW'(r_y[6]) <<< 25;

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r_ma    <= r_a[CMW-1] ? -r_a : r_a;
            r_mb    <= r_b[CMW-1] ? -r_b : r_b;
            r_my    <= y2_e[CMW-1] ? -y2_e : y2_e;
            r_inv7  <= r_inv6;
            r_pl    <= RW'(r_y[6]) + r_inv6;
            r_pr    <= RW'(r_y[6]) - r_inv6;
            r_ot1_7 <= r_ot1;
            r_ot2_7 <= r_ot2;
            r_pt1_7 <= r_pt1;
            r_pt2_7 <= r_pt2;
        end
    end

    // stage 8: axis select, grid-frame offset
    logic                 n_sec;
    logic signed [RW-1:0] n_o, n_p;
    logic signed [RW-1:0] r_o, r_p;

    always_comb begin
        n_sec = 1'b0;
        n_o   = '0;
        n_p   = '0;
        if (!r_zero[7]) begin
            unique case (r_style)
                STYLE_ORTHO: begin
                    n_sec = r_ssec[7];
                    if (n_sec) begin
                        n_p = RW'(r_y[7]);
                    end else begin
                        n_o = RW'(r_x[7]);
                    end
                end
                STYLE_ISO_LEFT: begin
                    n_sec = !(r_my < r_ma);
                    if (n_sec) begin
                        n_p = r_pl;
                    end else begin
                        n_o = RW'(r_x[7]);
                        n_p = -r_inv7;
                    end
                end
                STYLE_ISO_TOP: begin
                    n_sec = r_mb > r_ma;
                    if (n_sec) begin
                        n_o = r_ot2_7;
                        n_p = r_pt2_7;
                    end else begin
                        n_o = r_ot1_7;
                        n_p = r_pt1_7;
                    end
                end
                STYLE_ISO_RIGHT: begin
                    n_sec = r_my > r_mb;
                    if (n_sec) begin
                        n_p = r_pr;
                    end else begin
                        n_o = RW'(r_x[7]);
                        n_p = r_inv7;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r_o      <= n_o;
            r_p      <= n_p;
        end
    end

    // side-band delay lines, including their first stages
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_bx[1] <= i_base_x[CW-1:0];
            r_by[1] <= i_base_y[CW-1:0];
            r_bz[1] <= i_base_z[CW-1:0];
        end
        if (rdy[2]) begin
            r_zero[2] <= (r_dx == '0) && (r_dy == '0);
        end
        if (rdy[4]) begin
            r_x[4]    <= XW'((cx_e + (SW1'(1) <<< 15)) >>> 16);
            r_y[4]    <= XW'((cy_e + (SW1'(1) <<< 15)) >>> 16);
            r_ssec[4] <= cx_mag < cy_mag;
        end
        if (rdy[8]) begin
            r_sec[8] <= n_sec;
        end
        for (int k = 2; k <= 10; k++) begin
            if (rdy[k]) begin
                r_bx[k] <= r_bx[k-1];
                r_by[k] <= r_by[k-1];
            end
        end
        for (int k = 2; k <= NS; k++) begin
            if (rdy[k]) begin
                r_bz[k] <= r_bz[k-1];
            end
        end
        for (int k = 3; k <= 7; k++) begin
            if (rdy[k]) begin
                r_zero[k] <= r_zero[k-1];
            end
        end
        for (int k = 5; k <= 7; k++) begin
            if (rdy[k]) begin
                r_ssec[k] <= r_ssec[k-1];
                r_x[k]    <= r_x[k-1];
                r_y[k]    <= r_y[k-1];
            end
        end
        for (int k = 9; k <= NS; k++) begin
            if (rdy[k]) begin
                r_sec[k] <= r_sec[k-1];
            end
        end
    end

    // stage 9: back-rotation products
    logic signed [OPW-1:0] r_oc, r_ps, r_pc, r_os;

    always_ff @(posedge i_clk) begin
        if (rdy[9]) begin
            r_oc <= r_o * r_cos;
            r_ps <= r_p * r_sin;
            r_pc <= r_p * r_cos;
            r_os <= r_o * r_sin;
        end
    end

    // stage 10: offsets, Q16.16
    logic signed [OFW-1:0] r_offx, r_offy;

    always_ff @(posedge i_clk) begin
        if (rdy[10]) begin
            r_offx <= OFW'((EW1'(r_oc) - EW1'(r_ps) + (EW1'(1) <<< 15)) >>> 16);
            r_offy <= OFW'((EW1'(r_pc) + EW1'(r_os) + (EW1'(1) <<< 15)) >>> 16);
        end
    end

    // stage 11: add to base, saturate
    logic signed [BW-1:0] sum_x, sum_y;
    logic                 ovf_x, ovf_y;
    logic signed [CW-1:0] n_sx, n_sy;
    logic signed [CW-1:0] r_sx, r_sy;
    logic                 r_clip;

    always_comb begin
        sum_x = BW'(r_bx[10]) + BW'(r_offx);
        sum_y = BW'(r_by[10]) + BW'(r_offy);
        ovf_x = !((&sum_x[BW-1:CW-1]) || !(|sum_x[BW-1:CW-1]));
        ovf_y = !((&sum_y[BW-1:CW-1]) || !(|sum_y[BW-1:CW-1]));
        n_sx  = ovf_x ? {sum_x[BW-1], {(CW-1){!sum_x[BW-1]}}} : sum_x[CW-1:0];
        n_sy  = ovf_y ? {sum_y[BW-1], {(CW-1){!sum_y[BW-1]}}} : sum_y[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NS]) begin
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_clip <= ovf_x || ovf_y;
        end
    end

    assign o_snapped_x   = COORD_WIDTH'(r_sx);
    assign o_snapped_y   = COORD_WIDTH'(r_sy);
    assign o_snapped_z   = COORD_WIDTH'(r_bz[NS]);
    assign o_axis_chosen = r_sec[NS];
    assign o_clipped     = r_clip;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
    import oips_pkg::*;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED = 2'd3;
    localparam longint ROOT3_Q24     = 64'sd29058991;
    localparam longint INV_ROOT3_Q24 = 64'sd9686330;
    localparam longint ONE_Q24       = 64'sd16777216;
    localparam longint COORD_MAX     = 64'sd2147483647;
    localparam longint COORD_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
        logic [31:0] cx;
        logic [31:0] cy;
    } point_t;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        logic        axis;
        logic        clip;
    } snap_t;

    typedef enum int {STALL_NONE, STALL_SPARSE, STALL_ALTERNATE, STALL_HEAVY} stall_mode_t;

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_index = '0;
    logic [ANG_WIDTH-1:0]     i_cfg_data  = '0;
    logic                     i_valid     = 1'b0;
    logic [31:0]              i_base_x    = '0;
    logic [31:0]              i_base_y    = '0;
    logic [31:0]              i_base_z    = '0;
    logic [31:0]              i_cursor_x  = '0;
    logic [31:0]              i_cursor_y  = '0;
    logic                     i_stall     = 1'b0;
    logic                     o_cfg_ready;
    logic                     o_stall;
    logic                     o_valid;
    logic [31:0]              o_snapped_x;
    logic [31:0]              o_snapped_y;
    logic [31:0]              o_snapped_z;
    logic                     o_axis_chosen;
    logic                     o_clipped;

    longint grid_cos   = longint'(COS_RESET);
    longint grid_sin   = longint'(SIN_RESET);
    t_style grid_style = STYLE_ORTHO;

    point_t pending_points[$];
    snap_t  expected_snaps[$];
    point_t cur_point;
    snap_t  seen_snap;
    snap_t  want_snap;
    int     mismatches = 0;
    int     gap_left;
    int     burst_left;
    int     stall_run;
    stall_mode_t stall_mode;

    ortho_isometric_point_snap u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_base_x      (i_base_x),
        .i_base_y      (i_base_y),
        .i_base_z      (i_base_z),
        .i_cursor_x    (i_cursor_x),
        .i_cursor_y    (i_cursor_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_snapped_x   (o_snapped_x),
        .o_snapped_y   (o_snapped_y),
        .o_snapped_z   (o_snapped_z),
        .o_axis_chosen (o_axis_chosen),
        .o_clipped     (o_clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAIL ortho_isometric_point_snap");
        $finish;
    end

    // floor((v + 2^(n-1)) / 2^n)
    function automatic longint round_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic snap_t snap_point(point_t p);
        longint bx, by, dx, dy, c, s, offx, offy, t, gx, gy, xs, yo, o, q, sx, sy;
        logic   second;
        snap_t  r;
        bx = longint'($signed(p.bx));
        by = longint'($signed(p.by));
        dx = longint'($signed(p.cx)) - bx;
        dy = longint'($signed(p.cy)) - by;
        c = grid_cos;
        s = grid_sin;
        offx = 0;
        offy = 0;
        second = 1'b0;
        if (dx != 0 || dy != 0) begin
            if (grid_style == STYLE_ORTHO) begin
                gx = c * dx + s * dy;
                gy = c * dy - s * dx;
                if (mag(gx) >= mag(gy)) begin
                    t = round_shift(gx, 16);
                    offx = round_shift(t * c, 16);
                    offy = round_shift(t * s, 16);
                end else begin
                    second = 1'b1;
                    t = round_shift(gy, 16);
                    offx = round_shift(-t * s, 16);
                    offy = round_shift(t * c, 16);
                end
            end else begin
                // grid frame, then move along one iso axis onto the other
                gx = round_shift(c * dx + s * dy, 16);
                gy = round_shift(c * dy - s * dx, 16);
                xs = gx * ROOT3_Q24;
                yo = gy * ONE_Q24;
                case (grid_style)
                    STYLE_ISO_LEFT: begin
                        second = !(mag(2 * yo) < mag(xs - yo));
                        if (!second) begin
                            o = gx;
                            q = -round_shift(gx * INV_ROOT3_Q24, 24);
                        end else begin
                            o = 0;
                            q = gy + round_shift(gx * INV_ROOT3_Q24, 24);
                        end
                    end
                    STYLE_ISO_TOP: begin
                        second = mag(xs + yo) > mag(xs - yo);
                        if (second) begin
                            o = round_shift(gx * ONE_Q24 + gy * ROOT3_Q24, 25);
                            q = round_shift(yo + gx * INV_ROOT3_Q24, 25);
                        end else begin
                            o = round_shift(gx * ONE_Q24 - gy * ROOT3_Q24, 25);
                            q = round_shift(yo - gx * INV_ROOT3_Q24, 25);
                        end
                    end
                    default: begin
                        second = mag(2 * yo) > mag(xs + yo);
                        if (second) begin
                            o = 0;
                            q = gy - round_shift(gx * INV_ROOT3_Q24, 24);
                        end else begin
                            o = gx;
                            q = round_shift(gx * INV_ROOT3_Q24, 24);
                        end
                    end
                endcase
                offx = round_shift(o * c - q * s, 16);
                offy = round_shift(q * c + o * s, 16);
            end
        end
        sx = clamp_coord(bx + offx);
        sy = clamp_coord(by + offy);
        r.sx = sx[31:0];
        r.sy = sy[31:0];
        r.sz = p.bz;
        r.axis = second;
        r.clip = (sx != bx + offx) || (sy != by + offy);
        return r;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic void push_point(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                       logic [31:0] cx, logic [31:0] cy);
        pending_points.push_back('{bx, by, bz, cx, cy});
    endfunction

    function automatic logic [31:0] rand_span();
        logic [31:0] v;
        v = $urandom >> $urandom_range(1, 31);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic point_t rand_point();
        point_t      p;
        logic [31:0] dx, dy;
        longint      lean;
        p.bx = $urandom;
        p.by = $urandom;
        p.bz = $urandom;
        if ($urandom_range(0, 1)) begin
            p.bx = {{8{p.bx[23]}}, p.bx[23:0]};
            p.by = {{8{p.by[23]}}, p.by[23:0]};
        end
        case ($urandom_range(0, 11))
            0: begin
                dx = '0;
                dy = '0;
            end
            1, 2: begin
                dx = $urandom;
                dy = $urandom;
            end
            3: begin
                dx = rand_span();
                case ($urandom_range(0, 3))
                    0: dy = '0;
                    1: dy = dx;
                    2: dy = -dx;
                    default: begin
                        dy = dx;
                        dx = '0;
                    end
                endcase
            end
            4: begin
                // near an iso direction
                dy = rand_span();
                lean = (longint'($signed(dy)) * 113512) >>> 16;
                dx = lean[31:0] + $urandom_range(0, 3);
                if ($urandom_range(0, 1)) dx = -dx;
            end
            default: begin
                dx = rand_span();
                dy = rand_span();
            end
        endcase
        p.cx = p.bx + dx;
        p.cy = p.by + dy;
        return p;
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_points.size() != 0 || i_valid || expected_snaps.size() != 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [ANG_WIDTH-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_COS:   grid_cos = longint'($signed(val));
            CFG_SIN:   grid_sin = longint'($signed(val));
            CFG_STYLE: grid_style = t_style'(val[1:0]);
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [ANG_WIDTH-1:0] c, input logic [ANG_WIDTH-1:0] s,
                             input t_style style);
        write_reg(CFG_COS, c);
        write_reg(CFG_SIN, s);
        write_reg(CFG_STYLE, {16'd0, style});
    endtask

    task automatic random_grid();
        int c, s, k;
        int unit_c [5] = '{65536, 56756, 46341, 32768, 0};
        case ($urandom_range(0, 2))
            0: begin
                k = $urandom_range(0, 4);
                c = unit_c[k];
                s = unit_c[4 - k];
                if ($urandom_range(0, 1)) c = -c;
                if ($urandom_range(0, 1)) s = -s;
            end
            1: begin
                c = int'($urandom_range(0, 131072)) - 65536;
                s = int'($urandom_range(0, 131072)) - 65536;
            end
            default: begin
                c = 65536 * (int'($urandom_range(0, 2)) - 1);
                s = 65536 * (int'($urandom_range(0, 2)) - 1);
            end
        endcase
        configure(c[ANG_WIDTH-1:0], s[ANG_WIDTH-1:0], t_style'($urandom_range(0, 3)));
    endtask

    // sender: bursts of words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall)
                expected_snaps.push_back(snap_point(cur_point));
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0 || pending_points.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    cur_point = pending_points.pop_front();
                    i_base_x   <= cur_point.bx;
                    i_base_y   <= cur_point.by;
                    i_base_z   <= cur_point.bz;
                    i_cursor_x <= cur_point.cx;
                    i_cursor_y <= cur_point.cy;
                    i_valid    <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                            8:          gap_left = $urandom_range(5, 12);
                            default:    gap_left = $urandom_range(20, 40);
                        endcase
                    end
                end
            end
        end
    end

    // receiver: check result words, stall on a changing pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_mode = STALL_NONE;
            stall_run = 0;
        end else begin
            if (o_valid && !i_stall) begin
                seen_snap = {o_snapped_x, o_snapped_y, o_snapped_z, o_axis_chosen, o_clipped};
                if (expected_snaps.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word x=%h y=%h z=%h axis=%b clip=%b",
                        seen_snap.sx, seen_snap.sy, seen_snap.sz, seen_snap.axis,
                        seen_snap.clip));
                end else begin
                    want_snap = expected_snaps.pop_front();
                    if (seen_snap !== want_snap)
                        flag_mismatch($sformatf(
                            "exp x=%h y=%h z=%h axis=%b clip=%b got x=%h y=%h z=%h axis=%b clip=%b",
                            want_snap.sx, want_snap.sy, want_snap.sz, want_snap.axis,
                            want_snap.clip, seen_snap.sx, seen_snap.sy, seen_snap.sz,
                            seen_snap.axis, seen_snap.clip));
                end
            end
            if (stall_run == 0) begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_run = $urandom_range(16, 128);
            end
            stall_run--;
            case (stall_mode)
                STALL_NONE:      i_stall <= 1'b0;
                STALL_SPARSE:    i_stall <= ($urandom_range(0, 99) < 30);
                STALL_ALTERNATE: i_stall <= stall_run[0];
                default:         i_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    initial begin
        int random_left;
        int n;
        logic [ANG_WIDTH-1:0] iso_cos [4] = '{18'd0, 18'h10000, 18'd56756, 18'd0};
        logic [ANG_WIDTH-1:0] iso_sin [4] = '{18'd0, 18'd0, 18'd32768, 18'h30000};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset grid: zero offset, full-range offsets, tie
        push_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        push_point(32'h00000000, 32'h00000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
        push_point(32'h80000000, 32'h80000000, 32'h00000000, 32'h7fffffff, 32'h7fffffff);
        push_point(32'h7fffffff, 32'h7fffffff, 32'h12345678, 32'h80000000, 32'h7fffffff);
        push_point(32'h00010000, 32'hffff0000, 32'hffffffff, 32'h00020000, 32'h00000000);
        push_point(32'h00000000, 32'h00000000, 32'h00000000, 32'hffff0000, 32'h00030000);

        wait_drained();
        configure(18'h30000, 18'h10000, STYLE_ORTHO);
        write_reg(CFG_UNUSED, ANG_WIDTH'($urandom));
        push_point(32'h00000000, 32'h00000000, 32'h00000000, 32'h00050000, 32'hfffe0000);
        push_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);

        for (int k = 1; k < 4; k++) begin
            wait_drained();
            configure(iso_cos[k], iso_sin[k], t_style'(k));
            push_point(32'h00100000, 32'hfff00000, 32'h00000000, 32'h0011bb68, 32'hfff10000);
            push_point(32'h00100000, 32'hfff00000, 32'h00000001, 32'h00100000, 32'hfff10000);
            push_point(32'h00100000, 32'hfff00000, 32'h00000002, 32'h000e4498, 32'hfff10000);
            push_point(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
            push_point(32'h00100000, 32'hfff00000, 32'h80000000, 32'h00100000, 32'hfff00000);
        end

        random_left = 650;
        while (random_left > 0) begin
            wait_drained();
            random_grid();
            n = $urandom_range(30, 80);
            if (n > random_left) n = random_left;
            repeat (n) pending_points.push_back(rand_point());
            random_left -= n;
        end

        wait_drained();
        if (expected_snaps.size() != 0)
            flag_mismatch($sformatf("%0d words never arrived", expected_snaps.size()));
        if (mismatches == 0)
            $display("PASS ortho_isometric_point_snap");
        else
            $display("FAIL ortho_isometric_point_snap");
        $finish;
    end

endmodule

`default_nettype wire
